// ===== hdl/quintic_trajectory_generator_macros.svh =====
// ----------------------------------------------------------------------------
// quintic trajectory generator assertion macros
// shared property forms for the concurrent checks of the generator
// ----------------------------------------------------------------------------
`ifndef QUINTIC_TRAJECTORY_GENERATOR_MACROS_SVH
`define QUINTIC_TRAJECTORY_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define QTG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define QTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/qtg_pkg.sv =====
// ----------------------------------------------------------------------------
// qtg_pkg
// shared widths, codes, types and helpers of the quintic trajectory generator
// ----------------------------------------------------------------------------
package qtg_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int S_FRAC     = 30;
    localparam int H_FRAC     = 26;

    localparam int DUR_W     = 31;
    localparam int S_W       = S_FRAC + 1;
    localparam int DIFF_W    = DATA_WIDTH + 1;
    localparam int SHAPE_W   = 34;
    localparam int HQ_W      = 32;
    localparam int SUM_W     = 40;
    localparam int MAG_W     = 63;
    localparam int DF_W      = DIFF_W + SHAPE_W;
    localparam int POS_W     = DF_W - S_FRAC;
    localparam int VEL_SHIFT = S_FRAC - FRAC_BITS;
    localparam int ACC_K     = 2 * FRAC_BITS - H_FRAC;
    localparam int NV_W      = MAG_W - VEL_SHIFT;
    localparam int Y_W       = MAG_W - ACC_K;
    localparam int Q_W       = DATA_WIDTH;
    localparam int HQ_SHIFT  = S_FRAC - H_FRAC;

    localparam logic [DUR_W-1:0]      DUR_RESET = DUR_W'(65536);
    localparam logic [DATA_WIDTH-1:0] SAT_MAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_MIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {
        PHASE_BEFORE = 2'd0,
        PHASE_MOVING = 2'd1,
        PHASE_AFTER  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        REG_START_POS = 2'd0,
        REG_END_POS   = 2'd1,
        REG_DURATION  = 2'd2
    } cfg_index_t;

    // products handed from the shape polynomial unit
    typedef struct packed {
        phase_t                   phase;
        logic signed [DF_W-1:0]   df;
        logic [MAG_W-1:0]         dg_mag;
        logic                     dg_neg;
        logic [MAG_W-1:0]         dhq_mag;
        logic                     dhq_neg;
    } qtg_prod_t;

    typedef struct packed {
        phase_t                  phase;
        logic [DATA_WIDTH-1:0]   pos;
        logic [NV_W-1:0]         nv;
        logic                    vel_neg;
        logic                    vel_ovf;
        logic                    acc_neg;
        logic                    y_ovf;
    } qtg_ypay_t;

    typedef struct packed {
        phase_t                  phase;
        logic [DATA_WIDTH-1:0]   pos;
        logic                    vel_neg;
        logic                    vel_ovf;
    } qtg_vpay_t;

    typedef struct packed {
        logic acc_neg;
        logic acc_ovf;
    } qtg_apay_t;

    typedef struct packed {
        phase_t                  phase;
        logic [DATA_WIDTH-1:0]   acceleration;
        logic [DATA_WIDTH-1:0]   velocity;
        logic [DATA_WIDTH-1:0]   position;
    } qtg_out_t;

    // Q1.30 product, truncated back to Q1.30 (operands never exceed one)
    function automatic logic [S_W-1:0] qmul(input logic [S_W-1:0] a,
                                            input logic [S_W-1:0] b);
        logic [2*S_W-1:0] p;
        p = a * b;
        return p[S_FRAC+S_W-1:S_FRAC];
    endfunction

    // magnitude quotient plus sign to a saturated two's complement value
    function automatic logic [DATA_WIDTH-1:0] sign_sat(input logic [Q_W-1:0] q,
                                                       input logic ovf,
                                                       input logic neg);
        logic [DATA_WIDTH-1:0] r;
        if (ovf || q[Q_W-1]) begin
            r = neg ? SAT_MIN : SAT_MAX;
        end else begin
            r = neg ? (~q + 1'b1) : q;
        end
        return r;
    endfunction

endpackage

// ===== hdl/qtg_divider.sv =====
// ----------------------------------------------------------------------------
// qtg_divider
// pipelined restoring divider, one quotient bit per stage, payload alongside
// ----------------------------------------------------------------------------
module qtg_divider #(
    parameter int QW = 32,
    parameter int DW = 31,
    parameter int PW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic [DW-1:0] divisor,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [QW-1:0] in_bits,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_quot,
    output logic [PW-1:0] out_pay
);

    logic [DW-1:0] rem_reg   [QW];
    logic [QW-1:0] work_reg  [QW];
    logic [PW-1:0] pay_reg   [QW];
    logic          valid_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_step
        logic [DW-1:0] rem_in;
        logic [QW-1:0] work_in;
        logic [PW-1:0] pay_in;
        logic          valid_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;

        if (i == 0) begin : g_first
            assign rem_in   = in_rem;
            assign work_in  = in_bits;
            assign pay_in   = in_pay;
            assign valid_in = in_valid;
        end else begin : g_next
            assign rem_in   = rem_reg[i-1];
            assign work_in  = work_reg[i-1];
            assign pay_in   = pay_reg[i-1];
            assign valid_in = valid_reg[i-1];
        end

        // dividend bits leave at the top, quotient bits enter at the bottom
        assign trial = {rem_in, work_in[QW-1]};
        assign diff  = trial - {1'b0, divisor};
        assign take  = (trial >= {1'b0, divisor});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= take ? diff[DW-1:0] : trial[DW-1:0];
                work_reg[i] <= {work_in[QW-2:0], take};
                pay_reg[i]  <= pay_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= valid_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quot  = work_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];

endmodule

// ===== hdl/qtg_poly.sv =====
// ----------------------------------------------------------------------------
// qtg_poly
// powers of normalized time, shape polynomials and their products with d
// ----------------------------------------------------------------------------
module qtg_poly (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic signed [qtg_pkg::DIFF_W-1:0] d,
    input  logic [qtg_pkg::DIFF_W-1:0]        d_mag,
    input  logic                              d_neg,
    input  logic                              in_valid,
    input  logic [qtg_pkg::S_W-1:0]           in_s,
    input  qtg_pkg::phase_t                   in_phase,
    output logic                              out_valid,
    output qtg_pkg::qtg_prod_t                out_prod
);
    import qtg_pkg::*;

    localparam int STAGES = 6;

    logic   valid_reg [STAGES];
    phase_t phase_reg [STAGES-1];

    logic [S_W-1:0] s1_reg [4];
    logic [S_W-1:0] s2_reg [4];
    logic [S_W-1:0] s3_reg [3];
    logic [S_W-1:0] s4_reg [2];
    logic [S_W-1:0] s5_reg;

    logic signed [SHAPE_W-1:0] f_reg;
    logic signed [SHAPE_W-1:0] g_reg;
    logic signed [HQ_W-1:0]    hq_reg;
    qtg_prod_t                 prod_reg;

    logic signed [SUM_W-1:0] e1, e2, e3, e4, e5;
    logic signed [SUM_W-1:0] f_next, g_next, h_next;
    logic [SHAPE_W-2:0]      g_mag;
    logic [HQ_W-1:0]         hq_mag;
    logic [DIFF_W+SHAPE_W-2:0] dg_full;
    logic [DIFF_W+HQ_W-1:0]    dhq_full;

    assign e1 = SUM_W'(s1_reg[3]);
    assign e2 = SUM_W'(s2_reg[3]);
    assign e3 = SUM_W'(s3_reg[2]);
    assign e4 = SUM_W'(s4_reg[1]);
    assign e5 = SUM_W'(s5_reg);

    always_comb begin
        f_next = 40'sd10 * e3 - 40'sd15 * e4 + 40'sd6 * e5;
        g_next = 40'sd30 * e2 - 40'sd60 * e3 + 40'sd30 * e4;
        h_next = 40'sd60 * e1 - 40'sd180 * e2 + 40'sd120 * e3;
    end

    // velocity shape magnitude stays below 2^33
    assign g_mag    = (SHAPE_W-1)'(g_reg[SHAPE_W-1] ? -g_reg : g_reg);
    assign hq_mag   = hq_reg[HQ_W-1] ? HQ_W'(-hq_reg) : hq_reg;
    assign dg_full  = d_mag * g_mag;
    assign dhq_full = d_mag * hq_mag;

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1 to 4: one power per stage
            s1_reg[0] <= in_s;
            s2_reg[0] <= qmul(in_s, in_s);
            s1_reg[1] <= s1_reg[0];
            s2_reg[1] <= s2_reg[0];
            s3_reg[0] <= qmul(s2_reg[0], s1_reg[0]);
            s1_reg[2] <= s1_reg[1];
            s2_reg[2] <= s2_reg[1];
            s3_reg[1] <= s3_reg[0];
            s4_reg[0] <= qmul(s3_reg[0], s1_reg[1]);
            s1_reg[3] <= s1_reg[2];
            s2_reg[3] <= s2_reg[2];
            s3_reg[2] <= s3_reg[1];
            s4_reg[1] <= s4_reg[0];
            s5_reg    <= qmul(s4_reg[0], s1_reg[2]);
            // stage 5: shape polynomials, acceleration shape floored to q26
            f_reg  <= f_next[SHAPE_W-1:0];
            g_reg  <= g_next[SHAPE_W-1:0];
            hq_reg <= h_next[HQ_W+HQ_SHIFT-1:HQ_SHIFT];
            // stage 6: scale by the move distance
            prod_reg.phase   <= phase_reg[4];
            prod_reg.df      <= d * f_reg;
            prod_reg.dg_mag  <= dg_full[MAG_W-1:0];
            prod_reg.dg_neg  <= d_neg ^ g_reg[SHAPE_W-1];
            prod_reg.dhq_mag <= dhq_full[MAG_W-1:0];
            prod_reg.dhq_neg <= d_neg ^ hq_reg[HQ_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            phase_reg[0] <= in_phase;
            for (int i = 1; i < STAGES-1; i++) begin
                phase_reg[i] <= phase_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < STAGES; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_prod  = prod_reg;

endmodule

// ===== hdl/quintic_trajectory_generator.sv =====
// One request per cycle sustained while the output skid slot is empty.
// The pipeline depth is set mostly by the bit-serial divider pipelines: 31 stages for s = t/T,
// 57 for the acceleration pre-quotient and 32 for the velocity and acceleration.
// Reset (aresetn low, synchronous) empties the pipeline and output buffer and sets
// start and end position to 0 and duration to 1.0.
// ----------------------------------------------------------------------------
// quintic_trajectory_generator
// one-axis minimum-jerk point-to-point move: position, velocity, acceleration
// ----------------------------------------------------------------------------
`include "quintic_trajectory_generator_macros.svh"

module quintic_trajectory_generator (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    // time samples
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] sample_time
    // results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // position, velocity, acceleration, phase, pad
);
    import qtg_pkg::*;

    // configuration registers
    logic signed [DATA_WIDTH-1:0] p0_reg;
    logic signed [DATA_WIDTH-1:0] pt_reg;
    logic [DUR_W-1:0]             dur_reg;
    logic [DUR_W-1:0]             dur_eff;
    logic signed [DIFF_W-1:0]     d;
    logic [DIFF_W-1:0]            d_mag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_reg  <= '0;
            pt_reg  <= '0;
            dur_reg <= DUR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_START_POS: p0_reg  <= cfg_wdata;
                REG_END_POS:   pt_reg  <= cfg_wdata;
                REG_DURATION:  dur_reg <= cfg_wdata[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    assign dur_eff = (dur_reg == '0) ? DUR_W'(1) : dur_reg;
    assign d       = DIFF_W'(pt_reg) - DIFF_W'(p0_reg);
    assign d_mag   = d[DIFF_W-1] ? DIFF_W'(-d) : d;

    // pipeline advances as long as the skid slot is free
    logic en;
    logic skid_full_reg;
    assign en            = !skid_full_reg;
    assign s_axis_tready = en;

    // input stage: classify the sample
    logic                         in_valid_reg;
    logic signed [DATA_WIDTH-1:0] t_reg;
    phase_t                       in_phase_reg;
    phase_t                       in_phase_next;
    logic signed [DATA_WIDTH-1:0] t_in;

    assign t_in = s_axis_tdata;

    always_comb begin
        if (t_in[DATA_WIDTH-1]) begin
            in_phase_next = PHASE_BEFORE;
        end else if (t_in[DUR_W-1:0] > dur_eff) begin
            in_phase_next = PHASE_AFTER;
        end else begin
            in_phase_next = PHASE_MOVING;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg        <= t_in;
            in_phase_reg <= in_phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // s = t * 2^30 / T
    logic             moving_in;
    logic [DUR_W-1:0] s_rem;
    logic [S_W-1:0]   s_bits;
    logic             s_valid;
    logic [S_W-1:0]   s_quot;
    logic [1:0]       s_phase_bits;
    phase_t           s_phase;

    assign moving_in = (in_phase_reg == PHASE_MOVING);
    assign s_rem     = moving_in ? t_reg[DUR_W:1] : '0;
    assign s_bits    = moving_in ? {t_reg[0], {S_FRAC{1'b0}}} : '0;
    assign s_phase   = phase_t'(s_phase_bits);

    qtg_divider #(
        .QW (S_W),
        .DW (DUR_W),
        .PW (2)
    ) u_div_s (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .divisor   (dur_eff),
        .in_valid  (in_valid_reg),
        .in_rem    (s_rem),
        .in_bits   (s_bits),
        .in_pay    (in_phase_reg),
        .out_valid (s_valid),
        .out_quot  (s_quot),
        .out_pay   (s_phase_bits)
    );

    logic      poly_valid;
    qtg_prod_t prod;

    qtg_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .d         (d),
        .d_mag     (d_mag),
        .d_neg     (d[DIFF_W-1]),
        .in_valid  (s_valid),
        .in_s      (s_quot),
        .in_phase  (s_phase),
        .out_valid (poly_valid),
        .out_prod  (prod)
    );

    // prep stage: position, overflow checks of the two wide quotients
    logic signed [POS_W:0]      pos_sum;
    logic [DATA_WIDTH-1:0]      pos_sat;
    logic                       prep_valid_reg;
    qtg_ypay_t                  prep_pay_reg;
    logic [MAG_W-1:0]           ny_reg;

    assign pos_sum = (POS_W+1)'(p0_reg) + (POS_W+1)'($signed(prod.df[DF_W-1:S_FRAC]));

    always_comb begin
        if (pos_sum[POS_W:DATA_WIDTH-1] == '0 || pos_sum[POS_W:DATA_WIDTH-1] == '1) begin
            pos_sat = pos_sum[DATA_WIDTH-1:0];
        end else begin
            pos_sat = pos_sum[POS_W] ? SAT_MIN : SAT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_pay_reg.phase   <= prod.phase;
            prep_pay_reg.pos     <= pos_sat;
            prep_pay_reg.nv      <= prod.dg_mag[MAG_W-1:VEL_SHIFT];
            prep_pay_reg.vel_neg <= prod.dg_neg;
            prep_pay_reg.vel_ovf <= DUR_W'(prod.dg_mag[MAG_W-1:VEL_SHIFT+Q_W]) >= dur_eff;
            prep_pay_reg.acc_neg <= prod.dhq_neg;
            prep_pay_reg.y_ovf   <= DUR_W'(prod.dhq_mag[MAG_W-1:Y_W]) >= dur_eff;
            ny_reg               <= prod.dhq_mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (en) begin
            prep_valid_reg <= poly_valid;
        end
    end

    // y = d*hq / T
    logic [DUR_W-1:0] y_rem;
    logic             y_valid;
    logic [Y_W-1:0]   y_quot;
    qtg_ypay_t        y_pay;

    assign y_rem = prep_pay_reg.y_ovf ? '0 : DUR_W'(ny_reg[MAG_W-1:Y_W]);

    qtg_divider #(
        .QW ($bits(y_quot)),
        .DW (DUR_W),
        .PW ($bits(qtg_ypay_t))
    ) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .divisor   (dur_eff),
        .in_valid  (prep_valid_reg),
        .in_rem    (y_rem),
        .in_bits   (ny_reg[Y_W-1:0]),
        .in_pay    (prep_pay_reg),
        .out_valid (y_valid),
        .out_quot  (y_quot),
        .out_pay   (y_pay)
    );

    // mid stage: split into velocity and acceleration quotients
    logic                      mid_valid_reg;
    qtg_vpay_t                 mid_vpay_reg;
    qtg_apay_t                 mid_apay_reg;
    logic [NV_W-1:0]           mid_nv_reg;
    logic [Y_W-1:0]            mid_y_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_vpay_reg.phase   <= y_pay.phase;
            mid_vpay_reg.pos     <= y_pay.pos;
            mid_vpay_reg.vel_neg <= y_pay.vel_neg;
            mid_vpay_reg.vel_ovf <= y_pay.vel_ovf;
            mid_apay_reg.acc_neg <= y_pay.acc_neg;
            mid_apay_reg.acc_ovf <= y_pay.y_ovf || (y_quot[Y_W-1:Q_W-ACC_K] >= dur_eff);
            mid_nv_reg           <= y_pay.nv;
            mid_y_reg            <= y_quot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (en) begin
            mid_valid_reg <= y_valid;
        end
    end

    logic [DUR_W-1:0] v_rem;
    logic [DUR_W-1:0] a_rem;
    logic             vel_div_valid;
    logic             acc_div_valid;
    logic [Q_W-1:0]   vel_quot;
    logic [Q_W-1:0]   acc_quot;
    qtg_vpay_t        vel_pay;
    qtg_apay_t        acc_pay;

    assign v_rem = mid_vpay_reg.vel_ovf ? '0 : DUR_W'(mid_nv_reg[NV_W-1:Q_W]);
    assign a_rem = mid_apay_reg.acc_ovf ? '0 : mid_y_reg[Y_W-1:Q_W-ACC_K];

    qtg_divider #(
        .QW (Q_W),
        .DW (DUR_W),
        .PW ($bits(qtg_vpay_t))
    ) u_div_vel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .divisor   (dur_eff),
        .in_valid  (mid_valid_reg),
        .in_rem    (v_rem),
        .in_bits   (mid_nv_reg[Q_W-1:0]),
        .in_pay    (mid_vpay_reg),
        .out_valid (vel_div_valid),
        .out_quot  (vel_quot),
        .out_pay   (vel_pay)
    );

    qtg_divider #(
        .QW (Q_W),
        .DW (DUR_W),
        .PW ($bits(qtg_apay_t))
    ) u_div_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .divisor   (dur_eff),
        .in_valid  (mid_valid_reg),
        .in_rem    (a_rem),
        .in_bits   ({mid_y_reg[Q_W-ACC_K-1:0], {ACC_K{1'b0}}}),
        .in_pay    (mid_apay_reg),
        .out_valid (acc_div_valid),
        .out_quot  (acc_quot),
        .out_pay   (acc_pay)
    );

    // final values, held ends outside the move
    qtg_out_t final_data;

    always_comb begin
        final_data.phase        = vel_pay.phase;
        final_data.position     = vel_pay.pos;
        final_data.velocity     = '0;
        final_data.acceleration = '0;
        case (vel_pay.phase)
            PHASE_BEFORE: final_data.position = p0_reg;
            PHASE_AFTER:  final_data.position = pt_reg;
            default: begin
                final_data.velocity     = sign_sat(vel_quot, vel_pay.vel_ovf, vel_pay.vel_neg);
                final_data.acceleration = sign_sat(acc_quot, acc_pay.acc_ovf, acc_pay.acc_neg);
            end
        endcase
    end

    // output register with one skid slot
    logic     m_valid_reg;
    qtg_out_t m_data_reg;
    qtg_out_t skid_data_reg;
    logic     out_free;

    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else if (en) begin
            if (out_free) begin
                m_valid_reg <= vel_div_valid;
            end else if (vel_div_valid) begin
                skid_full_reg <= 1'b1;
            end
        end else if (m_axis_tready) begin
            skid_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (out_free) begin
                m_data_reg <= final_data;
            end else begin
                skid_data_reg <= final_data;
            end
        end else if (m_axis_tready) begin
            m_data_reg <= skid_data_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, m_data_reg};

    `QTG_ASSERT_SAME(a_div_aligned, aclk, aresetn, vel_div_valid || acc_div_valid, vel_div_valid && acc_div_valid, "velocity and acceleration dividers out of step")
    `QTG_ASSERT_SAME(a_hold_still, aclk, aresetn, m_valid_reg && m_data_reg.phase != PHASE_MOVING, m_data_reg.velocity == '0 && m_data_reg.acceleration == '0, "motion outside the move")
    `QTG_ASSERT_SAME(a_skid_behind_out, aclk, aresetn, skid_full_reg, m_valid_reg, "skid slot filled with output empty")
    `QTG_ASSERT_NEXT(a_skid_keeps, aclk, aresetn, skid_full_reg && !m_axis_tready, skid_full_reg, "skid slot dropped a result")

endmodule

// ===== verif/quintic_trajectory_checker.sv =====
// ----------------------------------------------------------------------------
// quintic trajectory checker
// watches the config port and both streams, computes the expected motion for
// every accepted time sample and compares it with the returned results
// ----------------------------------------------------------------------------
module quintic_trajectory_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,
    output int           err_count,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import qtg_pkg::*;

    typedef struct {
        logic [31:0] pos;
        logic [31:0] vel;
        logic [31:0] acc;
        phase_t      ph;
    } motion_t;

    logic signed [31:0] start_pos;
    logic signed [31:0] end_pos;
    logic [30:0]        dur_reg;
    motion_t            motion_q[$];

    function automatic logic [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647) return 32'h7fff_ffff;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic motion_t trajectory_point(input logic [31:0] t_raw);
        motion_t m;
        longint t, dur, d, s1, s2, s3, s4, s5, f, g, h, hq, y, lim;
        longint unsigned tu;
        t   = longint'($signed(t_raw));
        dur = (dur_reg == 0) ? 64'sd1 : longint'({33'd0, dur_reg});
        m.vel = '0;
        m.acc = '0;
        if (t < 0) begin
            m.pos = start_pos;
            m.ph  = PHASE_BEFORE;
        end else if (t > dur) begin
            m.pos = end_pos;
            m.ph  = PHASE_AFTER;
        end else begin
            tu = t;
            s1 = longint'((tu << S_FRAC) / longint'(dur));
            s2 = (s1 * s1) >>> S_FRAC;
            s3 = (s2 * s1) >>> S_FRAC;
            s4 = (s3 * s1) >>> S_FRAC;
            s5 = (s4 * s1) >>> S_FRAC;
            f  = 10 * s3 - 15 * s4 + 6 * s5;
            g  = 30 * s2 - 60 * s3 + 30 * s4;
            h  = 60 * s1 - 180 * s2 + 120 * s3;
            hq = h >>> HQ_SHIFT;
            d  = longint'(end_pos) - longint'(start_pos);
            lim = 64'sh7fff_ffff_ffff_ffff >>> ACC_K;
            m.pos = clamp32(longint'(start_pos) + ((d * f) >>> S_FRAC));
            m.vel = clamp32((d * g) / (dur <<< VEL_SHIFT));
            y = (d * hq) / dur;
            if (y > lim) m.acc = SAT_MAX;
            else if (y < -lim) m.acc = SAT_MIN;
            else m.acc = clamp32((y * (64'sd1 <<< ACC_K)) / dur);
            m.ph = PHASE_MOVING;
        end
        return m;
    endfunction

    always @(posedge aclk) begin
        motion_t exp_m;
        if (!aresetn) begin
            start_pos <= '0;
            end_pos   <= '0;
            dur_reg   <= DUR_RESET;
            motion_q.delete();
            err_count <= 0;
            pending   <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (motion_q.size() == 0) begin
                    $error("result with no request outstanding: %h", m_axis_tdata);
                    err_count <= err_count + 1;
                end else begin
                    exp_m = motion_q.pop_front();
                    if (m_axis_tdata[31:0] !== exp_m.pos ||
                        m_axis_tdata[63:32] !== exp_m.vel ||
                        m_axis_tdata[95:64] !== exp_m.acc ||
                        m_axis_tdata[97:96] !== exp_m.ph) begin
                        err_count <= err_count + 1;
                        if (m_axis_tdata[31:0] !== exp_m.pos)
                            $error("position exp %h got %h", exp_m.pos, m_axis_tdata[31:0]);
                        if (m_axis_tdata[63:32] !== exp_m.vel)
                            $error("velocity exp %h got %h", exp_m.vel, m_axis_tdata[63:32]);
                        if (m_axis_tdata[95:64] !== exp_m.acc)
                            $error("acceleration exp %h got %h", exp_m.acc,
                                   m_axis_tdata[95:64]);
                        if (m_axis_tdata[97:96] !== exp_m.ph)
                            $error("phase exp %0d got %0d", exp_m.ph, m_axis_tdata[97:96]);
                    end
                end
            end
            // prediction uses the settings in force before this edge's write
            if (s_axis_tvalid && s_axis_tready)
                motion_q.push_back(trajectory_point(s_axis_tdata));
            if (cfg_we) begin
                case (cfg_index)
                    REG_START_POS: start_pos <= cfg_wdata;
                    REG_END_POS:   end_pos   <= cfg_wdata;
                    REG_DURATION:  dur_reg   <= cfg_wdata[30:0];
                    default: ;
                endcase
            end
            pending <= motion_q.size();
        end
    end
endmodule

// ===== verif/tb_quintic_trajectory_generator.sv =====
// ----------------------------------------------------------------------------
// quintic trajectory generator testbench
// steps the generator through several move settings, sending directed and
// random time samples with random gaps and backpressure
// ----------------------------------------------------------------------------
module tb_quintic_trajectory_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import qtg_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 140;
    localparam int WATCHDOG_LIMIT = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    int           err_count;
    int           pending;
    int           idle_cycles = 0;
    logic [30:0]  cur_dur = DUR_RESET;

    always #5 aclk = ~aclk;

    quintic_trajectory_generator u_top (.*);
    quintic_trajectory_checker u_chk (.*);

    // receiver stalls: mostly short, sometimes long, sometimes none
    always @(posedge aclk) begin
        int r;
        r = $urandom_range(99);
        if (r < 60) m_axis_tready <= 1'b1;
        else if (r < 97) m_axis_tready <= 1'b0;
        else begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(40, 10)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_sample(input logic [31:0] t);
        int gap;
        int r;
        r = $urandom_range(99);
        gap = (r < 55) ? 0 : (r < 95) ? $urandom_range(3, 1) : $urandom_range(30, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_move(input logic [31:0] p0, input logic [31:0] pt,
                            input logic [30:0] dur);
        write_reg(REG_START_POS, p0);
        write_reg(REG_END_POS, pt);
        write_reg(REG_DURATION, {1'b0, dur});
        cur_dur = (dur == 0) ? 31'd1 : dur;
    endtask

    task automatic directed_samples();
        logic [31:0] d32;
        d32 = {1'b0, cur_dur};
        send_sample(32'h0000_0000);
        send_sample(d32);
        send_sample(d32 + 1);
        send_sample(32'hffff_ffff);
        send_sample(32'h8000_0000);
        send_sample(32'h7fff_ffff);
        send_sample(d32 >> 1);
        send_sample(d32 >> 2);
        send_sample(d32 - (d32 >> 3));
    endtask

    task automatic random_samples(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 80) send_sample($urandom_range(cur_dur, 0));
            else if (r < 88) send_sample($urandom() | 32'h8000_0000);
            else send_sample($urandom_range(32'h7fff_ffff, cur_dur));
        end
    endtask

    initial begin
        logic [30:0] dur;
        int r;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings first
        directed_samples();
        wait_drained();
        set_move(32'h8000_0000, 32'h7fff_ffff, 31'd1);
        directed_samples();
        wait_drained();
        set_move(32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
        directed_samples();
        random_samples(150);
        wait_drained();
        // zero duration acts as one lsb; index 3 write must be ignored
        set_move(32'h0001_0000, 32'hfff0_0000, 31'd0);
        write_reg(REG_UNUSED, 32'h1234_5678);
        directed_samples();
        wait_drained();
        set_move(32'h7fff_ffff, 32'h8000_0000, 31'd3);
        random_samples(60);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            r = $urandom_range(2);
            dur = (r == 0) ? 31'($urandom_range(4096, 1)) :
                  (r == 1) ? 31'($urandom_range(32'h0010_0000, 32'h0000_4000)) :
                  31'($urandom());
            set_move($urandom(), $urandom(), dur);
            random_samples(220);
            wait_drained();
        end

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
